[design/bmpa_pkg.sv]
// ----------------------------------------------------------------------------
// bmpa_pkg: shared types and constants for the basis matrix product block
// Item and status records that run along the row cell chain, field widths
// and command codes.
// ----------------------------------------------------------------------------
package bmpa_pkg;

    // Default sizes
    localparam int MAX_ROWS_DEF  = 64;
    localparam int MAX_TERMS_DEF = 256;

    // Field widths
    localparam int ROW_W   = 6;
    localparam int TERM_W  = 8;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 40;
    localparam int MAG_W   = 24;
    localparam int CNT_W   = 7;
    localparam int FRAC_W  = 15;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // Configuration register indexes
    localparam logic REG_ROW_COUNT = 1'b0;

    // One request traveling down the chain
    typedef struct packed {
        logic                     valid;
        logic                     cmd;
        logic                     term_ok;
        logic                     col_end;
        logic [ROW_W-1:0]         row_index;
        logic [TERM_W-1:0]        term_index;
        logic signed [VAL_W-1:0]  value;
    } cell_item_t;

    // Cell status toward the controller
    typedef struct packed {
        logic acc_end;
    } cell_stat_t;

endpackage

[design/basis_matrix_product_abs_top.sv]
// ----------------------------------------------------------------------------
// basis_matrix_product_abs_top: absolute basis matrix times column product
// Chain of row cells with an APB register port and stream ports.
// ----------------------------------------------------------------------------
// Load requests (tuser 0) and column elements (tuser 1) are taken one per
// cycle and travel down a chain of MAX_ROWS row cells, one cell per cycle;
// each cell owns one basis row and its 40-bit accumulator. A column element
// with tlast set closes the column: the input then holds off while that
// element reaches the end of the chain, whose length sets that wait, and
// while the magnitudes drain out of cell zero, one per active row, which
// an output stall holds up. Results come out in row order with tlast on
// the final active row. Row count is register 0; the user must write it
// only while the block is idle. The block itself does not enforce this.
// ----------------------------------------------------------------------------
module basis_matrix_product_abs_top
    import bmpa_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_TERMS = MAX_TERMS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // row_index[5:0], term_index[13:6], value[29:14]
    input  logic        s_axis_tuser,   // cmd
    input  logic        s_axis_tlast,   // column_end

    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_row[5:0], magnitude[29:6]
    output logic        m_axis_tlast    // last
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_WAIT,
        ST_CAPTURE,
        ST_DRAIN
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    row_count_reg;
    logic [CNT_W-1:0]    n_rows;
    logic [ROW_W-1:0]    drain_cnt_reg;
    logic                drain_last;
    logic                in_accept;
    logic                cfg_write;
    logic                capture;
    logic                shift;

    logic                out_valid_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [MAG_W-1:0]    out_mag_reg;
    logic                out_last_reg;
    logic [ACC_W-1:0]    rnd;
    logic [MAG_W-1:0]    mag;

    cell_item_t          items  [MAX_ROWS+1];
    logic [ACC_W-1:0]    drains [MAX_ROWS+1];
    cell_stat_t          stats  [MAX_ROWS];

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CNT_W'(1);
        end
        else if (cfg_write && (paddr[2] == REG_ROW_COUNT))
        begin
            row_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_ROW_COUNT)
        begin
            prdata = 32'(row_count_reg);
        end
    end

    // Clamp the active row count
    always_comb
    begin
        if (row_count_reg == '0)
        begin
            n_rows = CNT_W'(1);
        end
        else if (32'(row_count_reg) > MAX_ROWS)
        begin
            n_rows = CNT_W'(MAX_ROWS);
        end
        else
        begin
            n_rows = row_count_reg;
        end
    end

    // Build the request entering the chain
    assign s_axis_tready = (state_reg == ST_RUN);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign items[0] = '{
        valid:      in_accept,
        cmd:        s_axis_tuser,
        term_ok:    (32'(s_axis_tdata[13:6]) < MAX_TERMS),
        col_end:    s_axis_tlast,
        row_index:  s_axis_tdata[5:0],
        term_index: s_axis_tdata[13:6],
        value:      s_axis_tdata[29:14]
    };

    assign drains[MAX_ROWS] = '0;

    // Row cell chain
    for (genvar i = 0; i < MAX_ROWS; i++)
    begin : g_cell
        bmpa_cell #(
            .MAX_TERMS (MAX_TERMS),
            .ROW_ID    (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .item_in   (items[i]),
            .item_out  (items[i+1]),
            .capture   (capture),
            .shift     (shift),
            .drain_in  (drains[i+1]),
            .drain_out (drains[i]),
            .stat      (stats[i])
        );
    end

    // Sequencer
    assign capture    = (state_reg == ST_CAPTURE);
    assign shift      = (state_reg == ST_DRAIN) && (!out_valid_reg || m_axis_tready);
    assign drain_last = ((CNT_W'(drain_cnt_reg) + CNT_W'(1)) == n_rows);

    // Round and saturate the magnitude leaving cell zero
    assign rnd = drains[0] + ACC_W'(1 << (FRAC_W - 1));
    assign mag = (rnd[ACC_W-1:FRAC_W+MAG_W] != '0) ? '1 : rnd[FRAC_W+MAG_W-1:FRAC_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            drain_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_mag_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_RUN:
                begin
                    if (in_accept && (s_axis_tuser == CMD_DATA) && s_axis_tlast)
                    begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    if (stats[MAX_ROWS-1].acc_end)
                    begin
                        state_reg <= ST_CAPTURE;
                    end
                end
                ST_CAPTURE:
                begin
                    drain_cnt_reg <= '0;
                    state_reg     <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    if (shift)
                    begin
                        drain_cnt_reg <= drain_cnt_reg + ROW_W'(1);
                        if (drain_last)
                        begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase

            // Output register: load on shift, drop when taken
            if (shift)
            begin
                out_valid_reg <= 1'b1;
                out_row_reg   <= drain_cnt_reg;
                out_mag_reg   <= mag;
                out_last_reg  <= drain_last;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_mag_reg, out_row_reg};
    assign m_axis_tlast  = out_last_reg;

    // Checks
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> ((CNT_W'(out_row_reg) + CNT_W'(1)) == n_rows))
        else $error("tlast on a row other than the final active row");

    a_end_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (s_axis_tuser == CMD_DATA) && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken while a column closes");

    a_chain_quiet_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> !items[MAX_ROWS].valid)
        else $error("request still in the chain while draining");

    a_end_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        stats[MAX_ROWS-1].acc_end |-> (state_reg == ST_WAIT))
        else $error("column end reached chain end outside the wait state");

endmodule

[design/bmpa_cell.sv]
// ----------------------------------------------------------------------------
// bmpa_cell: one basis row of the chain
// Holds the row's basis elements, multiplies each passing column element by
// its basis element, accumulates with saturation and forwards the request to
// the next cell. On capture the magnitude of the sum joins the drain chain.
// ----------------------------------------------------------------------------
module bmpa_cell
    import bmpa_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int ROW_ID    = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_item_t         item_in,
    output cell_item_t         item_out,
    input  logic               capture,
    input  logic               shift,
    input  logic [ACC_W-1:0]   drain_in,
    output logic [ACC_W-1:0]   drain_out,
    output cell_stat_t         stat
);

    localparam int TW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    logic [VAL_W-1:0]         basis_mem [MAX_TERMS];
    logic [TW-1:0]            addr;
    logic                     wr_en;

    cell_item_t               item_reg;
    logic signed [VAL_W-1:0]  bdata_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_add_reg;
    logic                     prod_end_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W:0]    sum;
    logic [ACC_W-1:0]         drain_reg;
    logic [ACC_W-1:0]         acc_abs;

    assign addr  = TW'(item_in.term_index);
    assign wr_en = item_in.valid && (item_in.cmd == CMD_LOAD) && item_in.term_ok
                   && (item_in.row_index == ROW_W'(ROW_ID));

    // Basis row store: write on a matching load, read every cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            basis_mem[addr] <= item_in.value;
        end
        bdata_reg <= basis_mem[addr];
    end

    // Forward the request to the neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else
        begin
            item_reg <= item_in;
        end
    end

    // Multiply stage
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(bdata_reg) * PROD_W'(item_reg.value);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_add_reg <= 1'b0;
            prod_end_reg <= 1'b0;
        end
        else
        begin
            prod_add_reg <= item_reg.valid && (item_reg.cmd == CMD_DATA) && item_reg.term_ok;
            prod_end_reg <= item_reg.valid && (item_reg.cmd == CMD_DATA) && item_reg.col_end;
        end
    end

    // Saturating accumulate
    always_comb
    begin
        sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(prod_reg);
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            acc_next = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_next = sum[ACC_W-1:0];
        end
    end

    assign acc_abs = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (capture)
        begin
            acc_reg <= '0;
        end
        else if (prod_add_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // Drain chain: load the magnitude on capture, then shift toward row zero
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            drain_reg <= acc_abs;
        end
        else if (shift)
        begin
            drain_reg <= drain_in;
        end
    end

    assign item_out     = item_reg;
    assign drain_out    = drain_reg;
    assign stat.acc_end = prod_end_reg;

endmodule
